[sv/chgs_pkg.sv]
// Shared types and constants for the convex hull block.
package chgs_pkg;

  // Width of every coordinate field on the channels.
  localparam int FIELD_W = 16;

  typedef logic signed [FIELD_W-1:0] coord_t;

endpackage

[sv/chgs_if.sv]
// Channel interfaces for the point input and the hull vertex output.
interface chgs_in_if import chgs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;
  logic   last_point;

  modport source (output valid, output x_coord, output y_coord, output last_point,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input last_point,
                output ready);
endinterface

interface chgs_out_if import chgs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t hull_x;
  coord_t hull_y;
  logic   last_vertex;
  logic   points_dropped;

  modport source (output valid, output hull_x, output hull_y, output last_vertex,
                  output points_dropped, input ready);
  modport sink (input valid, input hull_x, input hull_y, input last_vertex,
                input points_dropped, output ready);
endinterface

[sv/chgs_xprod.sv]
// Cross product unit: ux*vy - uy*vx on one shared multiplier.
module chgs_xprod #(
  parameter int DW = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [DW-1:0]   ux,
  input  logic signed [DW-1:0]   uy,
  input  logic signed [DW-1:0]   vx,
  input  logic signed [DW-1:0]   vy,
  output logic signed [2*DW:0]   cr,
  output logic                   done
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_A    = 2'd1;
  localparam logic [1:0] PH_B    = 2'd2;
  localparam logic [1:0] PH_C    = 2'd3;

  logic [1:0]              phase_r, phase_nxt;
  logic                    done_r, done_nxt;
  logic signed [DW-1:0]    ux_r, uy_r, vx_r, vy_r;
  logic signed [2*DW-1:0]  prod_r, p1_r;
  logic signed [2*DW:0]    cr_r;
  logic signed [DW-1:0]    mul_a, mul_b;

  // The single multiplier takes ux*vy first, then uy*vx.
  assign mul_a = (phase_r == PH_A) ? ux_r : uy_r;
  assign mul_b = (phase_r == PH_A) ? vy_r : vx_r;

  // Phase sequencing.
  always_comb begin
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    unique case (phase_r)
      PH_IDLE: if (start) begin
        phase_nxt = PH_A;
      end
      PH_A: phase_nxt = PH_B;
      PH_B: phase_nxt = PH_C;
      PH_C: begin
        phase_nxt = PH_IDLE;
        done_nxt  = 1'b1;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // Operand capture, products and the final difference.
  always_ff @(posedge clk) begin
    if (phase_r == PH_IDLE && start) begin
      ux_r <= ux;
      uy_r <= uy;
      vx_r <= vx;
      vy_r <= vy;
    end
    if (phase_r == PH_A || phase_r == PH_B) begin
      prod_r <= mul_a * mul_b;
    end
    if (phase_r == PH_B) begin
      p1_r <= prod_r;
    end
    if (phase_r == PH_C) begin
      cr_r <= (2*DW+1)'(p1_r) - (2*DW+1)'(prod_r);
    end
  end

  assign cr   = cr_r;
  assign done = done_r;

endmodule

[sv/convex_hull_graham_scan.sv]
// Flow: points load at one word per cycle while the block is idle; after the last
// point the hull runs a pivot search, indexing, an insertion sort (N*N/2 steps
// worst case), the scan tests and the vertex emission. The shared cross product
// unit sets the step cost.
// Throughput: one set at a time; no point is taken while a hull is computed.
// Reset: synchronous, active low; clears the point count and flags, not the stores.
module convex_hull_graham_scan import chgs_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  chgs_in_if.sink     in_pt,
  chgs_out_if.source  out_hull
);

  localparam int IW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int DW  = COORD_BITS + 1;
  localparam int LW  = DW + 1;
  localparam int PW  = 2 * DW + 1;
  localparam int EXT = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_PV   = 5'd1;
  localparam logic [4:0] S_PC   = 5'd2;
  localparam logic [4:0] S_OR   = 5'd3;
  localparam logic [4:0] S_SK0  = 5'd4;
  localparam logic [4:0] S_SK1  = 5'd5;
  localparam logic [4:0] S_SK2  = 5'd6;
  localparam logic [4:0] S_SC0  = 5'd7;
  localparam logic [4:0] S_SC1  = 5'd8;
  localparam logic [4:0] S_SC2  = 5'd9;
  localparam logic [4:0] S_SC3  = 5'd10;
  localparam logic [4:0] S_SC4  = 5'd11;
  localparam logic [4:0] S_SI   = 5'd12;
  localparam logic [4:0] S_H0   = 5'd13;
  localparam logic [4:0] S_H1   = 5'd14;
  localparam logic [4:0] S_H2   = 5'd15;
  localparam logic [4:0] S_HP0  = 5'd16;
  localparam logic [4:0] S_HP1  = 5'd17;
  localparam logic [4:0] S_HP2  = 5'd18;
  localparam logic [4:0] S_HT   = 5'd19;
  localparam logic [4:0] S_HW   = 5'd20;
  localparam logic [4:0] S_HR0  = 5'd21;
  localparam logic [4:0] S_HR1  = 5'd22;
  localparam logic [4:0] S_HR2  = 5'd23;
  localparam logic [4:0] S_E0   = 5'd24;
  localparam logic [4:0] S_E1   = 5'd25;
  localparam logic [4:0] S_E2   = 5'd26;

  // Magnitude of a signed difference.
  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // Memories: point coordinates, sorted indices and the hull stack.
  logic signed [COORD_BITS-1:0] px_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] py_mem [MAX_POINTS];
  logic [IW-1:0]                ord_mem [MAX_POINTS];
  logic [IW-1:0]                stk_mem [MAX_POINTS];

  logic                         pt_we, pt_re, ord_we, ord_re, stk_we, stk_re;
  logic [IW-1:0]                pt_wa, pt_ra, ord_wa, ord_ra, stk_wa, stk_ra;
  logic [IW-1:0]                ord_wd, stk_wd;
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic [IW-1:0]                ord_q, stk_q;

  // Control registers.
  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          ov_r, ov_nxt;

  // Sequencer working registers.
  logic [CW-1:0] n_r, n_nxt, emit_n_r, emit_n_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, d_r, d_nxt;
  logic          run_ovf_r, run_ovf_nxt, small_r, small_nxt;
  logic [IW-1:0] piv_r, piv_nxt, key_r, key_nxt, cand_r, cand_nxt, t1i_r, t1i_nxt;
  logic signed [COORD_BITS-1:0] pvx_r, pvx_nxt, pvy_r, pvy_nxt;
  logic signed [COORD_BITS-1:0] t1x_r, t1x_nxt, t1y_r, t1y_nxt;
  logic signed [COORD_BITS-1:0] t2x_r, t2x_nxt, t2y_r, t2y_nxt;
  logic signed [COORD_BITS-1:0] t3x_r, t3x_nxt, t3y_r, t3y_nxt;
  logic signed [DW-1:0] kx_r, kx_nxt, ky_r, ky_nxt, cx_r, cx_nxt, cy_r, cy_nxt;

  // Output word register.
  coord_t ox_r, ox_nxt, oy_r, oy_nxt;
  logic   olast_r, olast_nxt, odrop_r, odrop_nxt;

  // Cross product unit connections.
  logic                 xp_start, xp_done;
  logic signed [DW-1:0] xp_ux, xp_uy, xp_vx, xp_vy;
  logic signed [PW-1:0] xp_cr;

  // Input conversion to the stored coordinate width.
  logic [EXT-1:0]               in_x_ext, in_y_ext;
  logic signed [COORD_BITS-1:0] in_x_c, in_y_c;
  logic signed [EXT-1:0]        ox_ext, oy_ext;
  logic                         in_fire, fits;
  logic [CW-1:0]                count_after;
  logic                         ovf_after;
  logic [LW-1:0]                l1k, l1c;
  logic                         prec, az, bz, piv_better;

  assign in_x_ext = EXT'($unsigned(in_pt.x_coord));
  assign in_y_ext = EXT'($unsigned(in_pt.y_coord));
  assign in_x_c   = $signed(in_x_ext[COORD_BITS-1:0]);
  assign in_y_c   = $signed(in_y_ext[COORD_BITS-1:0]);
  assign ox_ext   = EXT'(px_q);
  assign oy_ext   = EXT'(py_q);

  assign in_pt.ready = (state_r == S_IDLE);
  assign in_fire     = in_pt.valid && in_pt.ready;
  assign fits        = (count_r < CW'(MAX_POINTS));
  assign count_after = fits ? count_r + CW'(1) : count_r;
  assign ovf_after   = ovf_r || !fits;

  // Comparisons used by the sort and the pivot search.
  assign l1k = LW'(mag(kx_r)) + LW'(mag(ky_r));
  assign l1c = LW'(mag(cx_r)) + LW'(mag(cy_r));
  assign az  = (kx_r == '0) && (ky_r == '0);
  assign bz  = (cx_r == '0) && (cy_r == '0);
  assign prec = (xp_cr > 0) || ((xp_cr == '0) && (l1k < l1c));
  assign piv_better = (i_r == '0) || (py_q < pvy_r) || ((py_q == pvy_r) && (px_q < pvx_r));

  // Cross product operands: around the pivot in the sort, around t3 in the scan.
  always_comb begin
    if (state_r == S_HT) begin
      xp_ux = DW'(t2x_r) - DW'(t3x_r);
      xp_uy = DW'(t2y_r) - DW'(t3y_r);
      xp_vx = DW'(t1x_r) - DW'(t3x_r);
      xp_vy = DW'(t1y_r) - DW'(t3y_r);
    end else begin
      xp_ux = kx_r;
      xp_uy = ky_r;
      xp_vx = cx_r;
      xp_vy = cy_r;
    end
  end

  chgs_xprod #(.DW(DW)) u_xprod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (xp_start),
    .ux    (xp_ux),
    .uy    (xp_uy),
    .vx    (xp_vx),
    .vy    (xp_vy),
    .cr    (xp_cr),
    .done  (xp_done)
  );

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    ov_nxt      = ov_r && !out_hull.ready;
    n_nxt       = n_r;
    emit_n_nxt  = emit_n_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    d_nxt       = d_r;
    run_ovf_nxt = run_ovf_r;
    small_nxt   = small_r;
    piv_nxt     = piv_r;
    key_nxt     = key_r;
    cand_nxt    = cand_r;
    t1i_nxt     = t1i_r;
    pvx_nxt     = pvx_r;
    pvy_nxt     = pvy_r;
    t1x_nxt     = t1x_r;
    t1y_nxt     = t1y_r;
    t2x_nxt     = t2x_r;
    t2y_nxt     = t2y_r;
    t3x_nxt     = t3x_r;
    t3y_nxt     = t3y_r;
    kx_nxt      = kx_r;
    ky_nxt      = ky_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    olast_nxt   = olast_r;
    odrop_nxt   = odrop_r;
    pt_we       = 1'b0;
    pt_wa       = count_r[IW-1:0];
    pt_re       = 1'b0;
    pt_ra       = i_r[IW-1:0];
    ord_we      = 1'b0;
    ord_wa      = j_r[IW-1:0];
    ord_wd      = i_r[IW-1:0];
    ord_re      = 1'b0;
    ord_ra      = i_r[IW-1:0];
    stk_we      = 1'b0;
    stk_wa      = d_r[IW-1:0];
    stk_wd      = ord_q;
    stk_re      = 1'b0;
    stk_ra      = i_r[IW-1:0];
    xp_start    = 1'b0;

    unique case (state_r)
      // Load points; the last one starts the hull.
      S_IDLE: if (in_fire) begin
        pt_we     = fits;
        count_nxt = count_after;
        ovf_nxt   = ovf_after;
        if (in_pt.last_point) begin
          n_nxt       = count_after;
          run_ovf_nxt = ovf_after;
          count_nxt   = '0;
          ovf_nxt     = 1'b0;
          i_nxt       = '0;
          if (count_after < CW'(3)) begin
            small_nxt  = 1'b1;
            emit_n_nxt = count_after;
            state_nxt  = S_E1;
          end else begin
            small_nxt  = 1'b0;
            state_nxt  = S_PV;
          end
        end
      end
      // Pivot search: lowest, then leftmost.
      S_PV: begin
        pt_re     = 1'b1;
        state_nxt = S_PC;
      end
      S_PC: begin
        if (piv_better) begin
          piv_nxt = i_r[IW-1:0];
          pvx_nxt = px_q;
          pvy_nxt = py_q;
        end
        if (i_r == n_r - CW'(1)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_OR;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_PV;
        end
      end
      // List every index but the pivot.
      S_OR: begin
        if (i_r[IW-1:0] != piv_r) begin
          ord_we = 1'b1;
          j_nxt  = j_r + CW'(1);
        end
        if (i_r == n_r - CW'(1)) begin
          i_nxt     = CW'(1);
          state_nxt = S_SK0;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end
      // Insertion sort: fetch the key.
      S_SK0: begin
        ord_re    = 1'b1;
        state_nxt = S_SK1;
      end
      S_SK1: begin
        key_nxt   = ord_q;
        pt_re     = 1'b1;
        pt_ra     = ord_q;
        state_nxt = S_SK2;
      end
      S_SK2: begin
        kx_nxt    = DW'(px_q) - DW'(pvx_r);
        ky_nxt    = DW'(py_q) - DW'(pvy_r);
        j_nxt     = i_r;
        state_nxt = S_SC0;
      end
      // Fetch the candidate just below the insertion slot.
      S_SC0: begin
        if (j_r == '0) begin
          state_nxt = S_SI;
        end else begin
          ord_re    = 1'b1;
          ord_ra    = IW'(j_r - CW'(1));
          state_nxt = S_SC1;
        end
      end
      S_SC1: begin
        cand_nxt  = ord_q;
        pt_re     = 1'b1;
        pt_ra     = ord_q;
        state_nxt = S_SC2;
      end
      S_SC2: begin
        cx_nxt    = DW'(px_q) - DW'(pvx_r);
        cy_nxt    = DW'(py_q) - DW'(pvy_r);
        state_nxt = S_SC3;
      end
      // Points on the pivot sort first; otherwise angle, then distance.
      S_SC3: begin
        priority if (bz) begin
          state_nxt = S_SI;
        end else if (az) begin
          ord_we    = 1'b1;
          ord_wd    = cand_r;
          j_nxt     = j_r - CW'(1);
          state_nxt = S_SC0;
        end else begin
          xp_start  = 1'b1;
          state_nxt = S_SC4;
        end
      end
      S_SC4: if (xp_done) begin
        if (prec) begin
          ord_we    = 1'b1;
          ord_wd    = cand_r;
          j_nxt     = j_r - CW'(1);
          state_nxt = S_SC0;
        end else begin
          state_nxt = S_SI;
        end
      end
      S_SI: begin
        ord_we = 1'b1;
        ord_wd = key_r;
        if (i_r == n_r - CW'(2)) begin
          state_nxt = S_H0;
        end else begin
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SK0;
        end
      end
      // Scan start: pivot and the first sorted point.
      S_H0: begin
        stk_we    = 1'b1;
        stk_wa    = '0;
        stk_wd    = piv_r;
        ord_re    = 1'b1;
        ord_ra    = '0;
        t2x_nxt   = pvx_r;
        t2y_nxt   = pvy_r;
        state_nxt = S_H1;
      end
      S_H1: begin
        stk_we    = 1'b1;
        stk_wa    = IW'(1);
        cand_nxt  = ord_q;
        pt_re     = 1'b1;
        pt_ra     = ord_q;
        state_nxt = S_H2;
      end
      S_H2: begin
        t1i_nxt   = cand_r;
        t1x_nxt   = px_q;
        t1y_nxt   = py_q;
        d_nxt     = CW'(2);
        i_nxt     = CW'(1);
        state_nxt = S_HP0;
      end
      // Push the next sorted point.
      S_HP0: begin
        if (i_r == n_r - CW'(1)) begin
          small_nxt  = 1'b0;
          emit_n_nxt = d_r;
          i_nxt      = '0;
          state_nxt  = S_E0;
        end else begin
          ord_re    = 1'b1;
          state_nxt = S_HP1;
        end
      end
      S_HP1: begin
        stk_we    = 1'b1;
        cand_nxt  = ord_q;
        pt_re     = 1'b1;
        pt_ra     = ord_q;
        state_nxt = S_HP2;
      end
      S_HP2: begin
        t3x_nxt   = t2x_r;
        t3y_nxt   = t2y_r;
        t2x_nxt   = t1x_r;
        t2y_nxt   = t1y_r;
        t1i_nxt   = cand_r;
        t1x_nxt   = px_q;
        t1y_nxt   = py_q;
        d_nxt     = d_r + CW'(1);
        i_nxt     = i_r + CW'(1);
        state_nxt = S_HT;
      end
      // Turn test on the top three entries.
      S_HT: begin
        xp_start  = 1'b1;
        state_nxt = S_HW;
      end
      S_HW: if (xp_done) begin
        if (xp_cr < 0) begin
          stk_we  = 1'b1;
          stk_wa  = IW'(d_r - CW'(2));
          stk_wd  = t1i_r;
          t2x_nxt = t3x_r;
          t2y_nxt = t3y_r;
          d_nxt   = d_r - CW'(1);
          state_nxt = (d_r > CW'(3)) ? S_HR0 : S_HP0;
        end else begin
          state_nxt = S_HP0;
        end
      end
      // Refill the third entry from the stack after a pop.
      S_HR0: begin
        stk_re    = 1'b1;
        stk_ra    = IW'(d_r - CW'(3));
        state_nxt = S_HR1;
      end
      S_HR1: begin
        pt_re     = 1'b1;
        pt_ra     = stk_q;
        state_nxt = S_HR2;
      end
      S_HR2: begin
        t3x_nxt   = px_q;
        t3y_nxt   = py_q;
        state_nxt = S_HT;
      end
      // Emit vertices in stack order, or in arrival order for tiny sets.
      S_E0: begin
        stk_re    = 1'b1;
        state_nxt = S_E1;
      end
      S_E1: begin
        pt_re     = 1'b1;
        pt_ra     = small_r ? i_r[IW-1:0] : stk_q;
        state_nxt = S_E2;
      end
      S_E2: if (!ov_r || out_hull.ready) begin
        ov_nxt    = 1'b1;
        ox_nxt    = ox_ext[FIELD_W-1:0];
        oy_nxt    = oy_ext[FIELD_W-1:0];
        olast_nxt = (i_r == emit_n_r - CW'(1));
        odrop_nxt = run_ovf_r;
        i_nxt     = i_r + CW'(1);
        if (i_r == emit_n_r - CW'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = small_r ? S_E1 : S_E0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory ports with registered reads.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      px_mem[pt_wa] <= in_x_c;
      py_mem[pt_wa] <= in_y_c;
    end
    if (pt_re) begin
      px_q <= px_mem[pt_ra];
      py_q <= py_mem[pt_ra];
    end
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    if (ord_re) begin
      ord_q <= ord_mem[ord_ra];
    end
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and output word registers.
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    emit_n_r  <= emit_n_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    d_r       <= d_nxt;
    run_ovf_r <= run_ovf_nxt;
    small_r   <= small_nxt;
    piv_r     <= piv_nxt;
    key_r     <= key_nxt;
    cand_r    <= cand_nxt;
    t1i_r     <= t1i_nxt;
    pvx_r     <= pvx_nxt;
    pvy_r     <= pvy_nxt;
    t1x_r     <= t1x_nxt;
    t1y_r     <= t1y_nxt;
    t2x_r     <= t2x_nxt;
    t2y_r     <= t2y_nxt;
    t3x_r     <= t3x_nxt;
    t3y_r     <= t3y_nxt;
    kx_r      <= kx_nxt;
    ky_r      <= ky_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    ox_r      <= ox_nxt;
    oy_r      <= oy_nxt;
    olast_r   <= olast_nxt;
    odrop_r   <= odrop_nxt;
  end

  assign out_hull.valid          = ov_r;
  assign out_hull.hull_x         = ox_r;
  assign out_hull.hull_y         = oy_r;
  assign out_hull.last_vertex    = olast_r;
  assign out_hull.points_dropped = odrop_r;

`ifndef NO_ASSERTIONS
  // The stored point count never passes capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  // The cross product unit only finishes while the sequencer waits for it.
  a_xp_wait: assert property (@(posedge clk) disable iff (!rst_n)
    xp_done |-> (state_r == S_SC4 || state_r == S_HW))
    else $error("cross product result with no waiting step");

  // During the scan the stack holds at least three entries and no more than the set.
  a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HT || state_r == S_HW || state_r == S_HR0) |->
      (d_r > CW'(2) && d_r <= n_r))
    else $error("hull stack depth out of range");

  // A new output word is only loaded into a free or draining register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_hull.ready) |=> (ov_r && $stable(ox_r) && $stable(olast_r)))
    else $error("pending hull vertex overwritten");
`endif

endmodule
